[rtl/core/circular_arc_point_generator_assert.svh]
// Assertion macros used by the arc point generator checker.
`ifndef CIRCULAR_ARC_POINT_GENERATOR_ASSERT_SVH
`define CIRCULAR_ARC_POINT_GENERATOR_ASSERT_SVH

`define CAP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`define CAP_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

[rtl/core/cap_pkg.sv]
// Shared types, constants and functions of the arc point generator.
package cap_pkg;

  localparam int MAX_POINTS_DEF    = 1024;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_ENTRIES      = 24;

  localparam int IDX_W   = 10;
  localparam int CNT_W   = 11;
  localparam int ANG_W   = 18;
  localparam int RAD_W   = 24;
  localparam int COORD_W = 32;
  localparam int DATA_W  = 32;
  localparam int CFG_IDX_W = 3;

  localparam int DVD_W = 28;
  localparam int ZW    = 34;
  localparam int XW    = 33;
  localparam int PW    = RAD_W + 1 + XW;

  localparam logic [XW-1:0] INV_GAIN_Q30 = XW'(652032874);
  localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(64'sd1073741824);
  localparam logic signed [ZW-1:0] HALF_TURN    = ZW'(64'sd2147483648);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X      = 3'd0,
    CFG_CENTER_Y      = 3'd1,
    CFG_CENTER_Z      = 3'd2,
    CFG_ARC_RADIUS    = 3'd3,
    CFG_HEIGHT_OFFSET = 3'd4,
    CFG_START_ANGLE   = 3'd5,
    CFG_END_ANGLE     = 3'd6,
    CFG_POINT_COUNT   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic neg;
    logic oor;
  } div_tag_t;

  typedef struct packed {
    logic flip;
    logic oor;
  } rot_tag_t;

  function automatic logic [31:0] atan_entry(input int i);
    logic [31:0] v;
    case (i)
      0: v = 32'd536870912;
      1: v = 32'd316933406;
      2: v = 32'd167458907;
      3: v = 32'd85004756;
      4: v = 32'd42667331;
      5: v = 32'd21354465;
      6: v = 32'd10679838;
      7: v = 32'd5340245;
      8: v = 32'd2670163;
      9: v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  function automatic logic [COORD_W-1:0] sat34(input logic signed [33:0] v);
    logic [COORD_W-1:0] r;
    if ((v[33] == v[32]) && (v[32] == v[31])) begin
      r = v[31:0];
    end else if (v[33]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7FFF_FFFF;
    end
    return r;
  endfunction

endpackage

[rtl/core/cap_divider.sv]
// Pipelined restoring divider, one quotient bit per stage.
module cap_divider #(
  parameter int CW = 11,
  parameter int NW = 28
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [NW-1:0]        in_dvd,
  input  cap_pkg::div_tag_t    in_tag,
  input  logic [CW-1:0]        divisor,
  output logic                 out_valid,
  output logic [NW-1:0]        out_quo,
  output cap_pkg::div_tag_t    out_tag
);

  logic [CW-1:0]     rem_r [NW];
  logic [NW-1:0]     dq_r  [NW];
  logic              v_r   [NW];
  cap_pkg::div_tag_t tag_r [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [CW-1:0]     prev_rem;
    logic [NW-1:0]     prev_dq;
    logic              prev_v;
    cap_pkg::div_tag_t prev_tag;
    logic [CW:0]       trial;
    logic              ge;
    logic [CW:0]       diff;
    logic [CW-1:0]     rem_nxt;
    logic [NW-1:0]     dq_nxt;

    if (k == 0) begin : g_first
      assign prev_rem = '0;
      assign prev_dq  = in_dvd;
      assign prev_v   = in_valid;
      assign prev_tag = in_tag;
    end else begin : g_next
      assign prev_rem = rem_r[k-1];
      assign prev_dq  = dq_r[k-1];
      assign prev_v   = v_r[k-1];
      assign prev_tag = tag_r[k-1];
    end

    assign trial   = {prev_rem, prev_dq[NW-1]};
    assign ge      = trial >= {1'b0, divisor};
    assign diff    = trial - {1'b0, divisor};
    assign rem_nxt = ge ? diff[CW-1:0] : trial[CW-1:0];
    assign dq_nxt  = {prev_dq[NW-2:0], ge};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= prev_v;
      end
      if (en) begin
        rem_r[k] <= rem_nxt;
        dq_r[k]  <= dq_nxt;
        tag_r[k] <= prev_tag;
      end
    end
  end

  assign out_valid = v_r[NW-1];
  assign out_quo   = dq_r[NW-1];
  assign out_tag   = tag_r[NW-1];

endmodule

[rtl/core/cap_cordic.sv]
// Unrolled rotation-mode CORDIC, one register stage per iteration.
module cap_cordic #(
  parameter int STAGES = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic signed [cap_pkg::ZW-1:0]  in_z,
  input  cap_pkg::rot_tag_t              in_tag,
  output logic                           out_valid,
  output logic signed [cap_pkg::XW-1:0]  out_x,
  output logic signed [cap_pkg::XW-1:0]  out_y,
  output cap_pkg::rot_tag_t              out_tag
);

  localparam int NS = (STAGES > cap_pkg::ATAN_ENTRIES) ? cap_pkg::ATAN_ENTRIES : STAGES;
  localparam int ZW = cap_pkg::ZW;
  localparam int XW = cap_pkg::XW;

  logic signed [XW-1:0] x_r [NS];
  logic signed [XW-1:0] y_r [NS];
  logic signed [ZW-1:0] z_r [NS];
  logic                 v_r [NS];
  cap_pkg::rot_tag_t    tag_r [NS];

  for (genvar i = 0; i < NS; i++) begin : g_stage
    localparam logic signed [ZW-1:0] ATAN = ZW'(cap_pkg::atan_entry(i));
    logic signed [XW-1:0] px, py, dx, dy, x_nxt, y_nxt;
    logic signed [ZW-1:0] pz, z_nxt;
    logic                 pv;
    cap_pkg::rot_tag_t    ptag;

    if (i == 0) begin : g_first
      assign px   = cap_pkg::INV_GAIN_Q30;
      assign py   = '0;
      assign pz   = in_z;
      assign pv   = in_valid;
      assign ptag = in_tag;
    end else begin : g_next
      assign px   = x_r[i-1];
      assign py   = y_r[i-1];
      assign pz   = z_r[i-1];
      assign pv   = v_r[i-1];
      assign ptag = tag_r[i-1];
    end

    assign dx = py >>> i;
    assign dy = px >>> i;

    always_comb begin
      if (!pz[ZW-1]) begin
        x_nxt = px - dx;
        y_nxt = py + dy;
        z_nxt = pz - ATAN;
      end else begin
        x_nxt = px + dx;
        y_nxt = py - dy;
        z_nxt = pz + ATAN;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= pv;
      end
      if (en) begin
        x_r[i]   <= x_nxt;
        y_r[i]   <= y_nxt;
        z_r[i]   <= z_nxt;
        tag_r[i] <= ptag;
      end
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_x     = x_r[NS-1];
  assign out_y     = y_r[NS-1];
  assign out_tag   = tag_r[NS-1];

endmodule

[rtl/core/cap_scale.sv]
// Radius scaling, center offset, saturation and the output register.
module cap_scale (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic signed [cap_pkg::XW-1:0]       in_x,
  input  logic signed [cap_pkg::XW-1:0]       in_y,
  input  cap_pkg::rot_tag_t                   in_tag,
  input  logic [cap_pkg::RAD_W-1:0]           radius,
  input  logic [cap_pkg::COORD_W-1:0]         cx,
  input  logic [cap_pkg::COORD_W-1:0]         cy,
  input  logic [cap_pkg::COORD_W-1:0]         cz,
  input  logic [cap_pkg::COORD_W-1:0]         hz,
  output logic                                out_valid,
  output logic [cap_pkg::COORD_W-1:0]         out_x,
  output logic [cap_pkg::COORD_W-1:0]         out_y,
  output logic [cap_pkg::COORD_W-1:0]         out_z,
  output logic                                out_oor
);

  localparam int XW = cap_pkg::XW;
  localparam int PW = cap_pkg::PW;
  localparam logic signed [PW-1:0] HALF_LSB = PW'(64'sd536870912);

  logic signed [XW-1:0] xf, yf;
  logic signed [PW-1:0] pc, ps;
  logic signed [PW-1:0] pc_r, ps_r, tc, ts;
  logic                 v_r, oor_r;
  logic signed [33:0]   sx, sy, sz;
  logic                 ov_r, oo_r;
  logic [cap_pkg::COORD_W-1:0] px_r, py_r, pz_r;

  assign xf = in_tag.flip ? -in_x : in_x;
  assign yf = in_tag.flip ? -in_y : in_y;
  assign pc = $signed({1'b0, radius}) * xf;
  assign ps = $signed({1'b0, radius}) * yf;

  assign tc = pc_r + HALF_LSB;
  assign ts = ps_r + HALF_LSB;
  assign sx = {{2{cx[31]}}, cx} + {{6{tc[PW-1]}}, tc[PW-1:30]};
  assign sy = {{2{cy[31]}}, cy} + {{6{ts[PW-1]}}, ts[PW-1:30]};
  assign sz = {{2{cz[31]}}, cz} + {{2{hz[31]}}, hz};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= 1'b0;
      ov_r <= 1'b0;
    end else if (en) begin
      v_r  <= in_valid;
      ov_r <= v_r;
    end
    if (en) begin
      pc_r  <= pc;
      ps_r  <= ps;
      oor_r <= in_tag.oor;
      oo_r  <= oor_r;
      px_r  <= oor_r ? '0 : cap_pkg::sat34(sx);
      py_r  <= oor_r ? '0 : cap_pkg::sat34(sy);
      pz_r  <= oor_r ? '0 : cap_pkg::sat34(sz);
    end
  end

  assign out_valid = ov_r;
  assign out_x     = px_r;
  assign out_y     = py_r;
  assign out_z     = pz_r;
  assign out_oor   = oo_r;

endmodule

[rtl/core/circular_arc_point_generator.sv]
// Circular arc point generator top level.
// Each in word carries a point index and returns one out word with that point
// of the configured arc: the angle start + trunc(index * (end - start) / count),
// then x = cx + r*cos, y = cy + r*sin and z = cz + height, saturated to 32 bits.
// An index not below the count, or a count of zero, returns out_of_range with
// zero coordinates. One word is taken every cycle in which no out word waits;
// the pipeline is made of the 28 stages of the pipelined angle divider, one
// register per CORDIC iteration and four arithmetic stages. The whole pipeline
// halts while an out word waits. Registers may be written only while no word
// is in flight.
module circular_arc_point_generator #(
  parameter int MAX_POINTS    = cap_pkg::MAX_POINTS_DEF,
  parameter int CORDIC_STAGES = cap_pkg::CORDIC_STAGES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [cap_pkg::IDX_W-1:0]         in_point_index,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [cap_pkg::COORD_W-1:0]       out_pos_x,
  output logic [cap_pkg::COORD_W-1:0]       out_pos_y,
  output logic [cap_pkg::COORD_W-1:0]       out_pos_z,
  output logic                              out_out_of_range,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cap_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cap_pkg::DATA_W-1:0]        cfg_data
);

  localparam int MPW = $clog2(MAX_POINTS + 1);
  localparam int CW  = (MPW > cap_pkg::CNT_W) ? MPW : cap_pkg::CNT_W;
  localparam int NW  = cap_pkg::DVD_W;
  localparam int ZW  = cap_pkg::ZW;
  localparam int XW  = cap_pkg::XW;

  logic [31:0]               center_x_r, center_y_r, center_z_r, height_r;
  logic [cap_pkg::RAD_W-1:0] radius_r;
  logic signed [cap_pkg::ANG_W-1:0] start_r, end_r;
  logic [cap_pkg::CNT_W-1:0] count_r;

  logic en;
  logic [CW-1:0] cnt_ext, cnt_eff;
  logic signed [cap_pkg::ANG_W:0] diff;
  logic signed [cap_pkg::ANG_W+cap_pkg::IDX_W:0] prod;
  logic [NW-1:0] mag;
  logic          in_oor;

  logic              s0_v_r;
  logic [NW-1:0]     s0_mag_r;
  cap_pkg::div_tag_t s0_tag_r;

  logic              dv_valid;
  logic [NW-1:0]     dv_quo;
  cap_pkg::div_tag_t dv_tag;

  logic [15:0]          q16, qs, theta16;
  logic signed [ZW-1:0] zw, zf;
  logic                 flip;

  logic                 s1_v_r;
  logic signed [ZW-1:0] s1_z_r;
  cap_pkg::rot_tag_t    s1_tag_r;

  logic                 cr_valid;
  logic signed [XW-1:0] cr_x, cr_y;
  cap_pkg::rot_tag_t    cr_tag;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      center_z_r <= '0;
      radius_r   <= '0;
      height_r   <= '0;
      start_r    <= '0;
      end_r      <= '0;
      count_r    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cap_pkg::CFG_CENTER_X:      center_x_r <= cfg_data;
        cap_pkg::CFG_CENTER_Y:      center_y_r <= cfg_data;
        cap_pkg::CFG_CENTER_Z:      center_z_r <= cfg_data;
        cap_pkg::CFG_ARC_RADIUS:    radius_r   <= cfg_data[cap_pkg::RAD_W-1:0];
        cap_pkg::CFG_HEIGHT_OFFSET: height_r   <= cfg_data;
        cap_pkg::CFG_START_ANGLE:   start_r    <= cfg_data[cap_pkg::ANG_W-1:0];
        cap_pkg::CFG_END_ANGLE:     end_r      <= cfg_data[cap_pkg::ANG_W-1:0];
        cap_pkg::CFG_POINT_COUNT:   count_r    <= cfg_data[cap_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  assign cnt_ext = CW'(count_r);
  assign cnt_eff = (cnt_ext > CW'(MAX_POINTS)) ? CW'(MAX_POINTS) : cnt_ext;
  assign in_oor  = (cnt_eff == '0) || (CW'(in_point_index) >= cnt_eff);

  assign diff = {end_r[cap_pkg::ANG_W-1], end_r} - {start_r[cap_pkg::ANG_W-1], start_r};
  assign prod = $signed({1'b0, in_point_index}) * diff;
  assign mag  = prod[cap_pkg::ANG_W+cap_pkg::IDX_W] ? NW'(-prod) : NW'(prod);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_valid;
    end
    if (en) begin
      s0_mag_r     <= mag;
      s0_tag_r.neg <= prod[cap_pkg::ANG_W+cap_pkg::IDX_W];
      s0_tag_r.oor <= in_oor;
    end
  end

  cap_divider #(.CW(CW), .NW(NW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s0_v_r),
    .in_dvd    (s0_mag_r),
    .in_tag    (s0_tag_r),
    .divisor   (cnt_eff),
    .out_valid (dv_valid),
    .out_quo   (dv_quo),
    .out_tag   (dv_tag)
  );

  assign q16     = dv_quo[15:0];
  assign qs      = dv_tag.neg ? -q16 : q16;
  assign theta16 = start_r[15:0] + qs;
  assign zw      = {{(ZW-32){theta16[15]}}, theta16, 16'h0000};

  always_comb begin
    if (zw > cap_pkg::QUARTER_TURN) begin
      zf   = zw - cap_pkg::HALF_TURN;
      flip = 1'b1;
    end else if (zw < -cap_pkg::QUARTER_TURN) begin
      zf   = zw + cap_pkg::HALF_TURN;
      flip = 1'b1;
    end else begin
      zf   = zw;
      flip = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= dv_valid;
    end
    if (en) begin
      s1_z_r        <= zf;
      s1_tag_r.flip <= flip;
      s1_tag_r.oor  <= dv_tag.oor;
    end
  end

  cap_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s1_v_r),
    .in_z      (s1_z_r),
    .in_tag    (s1_tag_r),
    .out_valid (cr_valid),
    .out_x     (cr_x),
    .out_y     (cr_y),
    .out_tag   (cr_tag)
  );

  cap_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (cr_valid),
    .in_x      (cr_x),
    .in_y      (cr_y),
    .in_tag    (cr_tag),
    .radius    (radius_r),
    .cx        (center_x_r),
    .cy        (center_y_r),
    .cz        (center_z_r),
    .hz        (height_r),
    .out_valid (out_valid),
    .out_x     (out_pos_x),
    .out_y     (out_pos_y),
    .out_z     (out_pos_z),
    .out_oor   (out_out_of_range)
  );

endmodule

[rtl/core/cap_checker.sv]
// Port-level checker for the arc point generator and its bind statement.
`include "circular_arc_point_generator_assert.svh"

module cap_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_pos_x,
  input logic [31:0] out_pos_y,
  input logic [31:0] out_pos_z,
  input logic        out_out_of_range
);

  `CAP_ASSERT(a_reset_empty, !rst_n |=> !out_valid, "out word present right after reset")
  `CAP_ASSERT_RST(a_oor_zero, (out_valid && out_out_of_range) |-> ((out_pos_x == 32'h0) && (out_pos_y == 32'h0) && (out_pos_z == 32'h0)), "out-of-range word with nonzero coordinates")
  `CAP_ASSERT_RST(a_ready_flow, out_ready |-> in_ready, "input stalled while output drains")
  `CAP_ASSERT_RST(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_pos_x) && $stable(out_pos_y) && $stable(out_pos_z)), "stalled out word changed")

endmodule

bind circular_arc_point_generator cap_checker u_cap_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_pos_x        (out_pos_x),
  .out_pos_y        (out_pos_y),
  .out_pos_z        (out_pos_z),
  .out_out_of_range (out_out_of_range)
);

[verif/tb_top.sv]
// Self-checking testbench for the circular arc point generator: predicted arc points vs DUT.
module tb_top;

  localparam int LATENCY     = cap_pkg::CORDIC_STAGES_DEF + 32;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic        oor;
  } arc_point_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [9:0]  in_point_index;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_pos_x;
  logic [31:0] out_pos_y;
  logic [31:0] out_pos_z;
  logic        out_out_of_range;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  circular_arc_point_generator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_point_index(in_point_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z),
    .out_out_of_range(out_out_of_range),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  longint arc_cx, arc_cy, arc_cz, arc_rad, arc_hgt, arc_start, arc_end, arc_cnt;
  arc_point_t pending_points[$];
  int errors;
  int points_checked;
  int oor_seen;
  int sat_seen;
  int cycles;
  int burst_left;
  bit hold_req;
  int hold_left;
  bit steady_rx;

  localparam longint ATAN_Q32[16] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861
  };

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic arc_point_t arc_point(logic [9:0] idx);
    arc_point_t p;
    longint cnt, theta, z, x, y, dx, dy, rc, rs;
    logic [15:0] a;
    bit flip;
    cnt = (arc_cnt > 1024) ? 1024 : arc_cnt;
    p.px = '0;
    p.py = '0;
    p.pz = '0;
    p.oor = 1'b1;
    if (cnt == 0 || longint'(idx) >= cnt) return p;
    theta = arc_start + (longint'(idx) * (arc_end - arc_start)) / cnt;
    a = theta[15:0];
    z = longint'(a) << 16;
    if (a[15]) z -= 64'sd4294967296;
    flip = 0;
    if (z > 64'sd1073741824) begin
      z -= 64'sd2147483648;
      flip = 1;
    end else if (z < -64'sd1073741824) begin
      z += 64'sd2147483648;
      flip = 1;
    end
    x = 652032874;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_Q32[i];
      end else begin
        x += dx; y -= dy; z += ATAN_Q32[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    rc = (arc_rad * x + (64'sd1 <<< 29)) >>> 30;
    rs = (arc_rad * y + (64'sd1 <<< 29)) >>> 30;
    p.px = clamp32(arc_cx + rc);
    p.py = clamp32(arc_cy + rs);
    p.pz = clamp32(arc_cz + arc_hgt);
    p.oor = 1'b0;
    return p;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("Mismatch on %s at cycle %0d: got %h, expected %h", what, cycles, got, want);
  endtask

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      pending_points = {pending_points, arc_point(in_point_index)};
    end
  end

  always @(posedge clk) begin
    arc_point_t w;
    if (rst_n && out_valid && out_ready) begin
      if (pending_points.size() == 0) begin
        report("unexpected word", out_pos_x, 32'h0);
      end else begin
        w = pending_points.pop_front();
        points_checked++;
        if (w.oor) oor_seen++;
        if (!w.oor && (w.px == 32'h7FFF_FFFF || w.px == 32'h8000_0000 ||
                       w.py == 32'h7FFF_FFFF || w.py == 32'h8000_0000 ||
                       w.pz == 32'h7FFF_FFFF || w.pz == 32'h8000_0000)) sat_seen++;
        if (out_pos_x !== w.px) report("pos_x", out_pos_x, w.px);
        if (out_pos_y !== w.py) report("pos_y", out_pos_y, w.py);
        if (out_pos_z !== w.pz) report("pos_z", out_pos_z, w.pz);
        if (out_out_of_range !== w.oor) begin
          report("out_of_range", {31'b0, out_out_of_range}, {31'b0, w.oor});
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = 400;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (steady_rx) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= (cycles % 37 < 20) ? ($urandom_range(0, 3) != 0) : 1'b1;
    end
  end

  task automatic send_point(logic [9:0] idx);
    in_valid <= 1'b1;
    in_point_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic pause_input(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic paced_point(logic [9:0] idx);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 2) != 0) pause_input($urandom_range(1, 6));
    end
    burst_left--;
    send_point(idx);
  endtask

  task automatic wait_drained();
    pause_input(1);
    while (pending_points.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(cap_pkg::cfg_reg_t r, logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (r)
      cap_pkg::CFG_CENTER_X:      arc_cx = longint'($signed(v));
      cap_pkg::CFG_CENTER_Y:      arc_cy = longint'($signed(v));
      cap_pkg::CFG_CENTER_Z:      arc_cz = longint'($signed(v));
      cap_pkg::CFG_ARC_RADIUS:    arc_rad = longint'(v[23:0]);
      cap_pkg::CFG_HEIGHT_OFFSET: arc_hgt = longint'($signed(v));
      cap_pkg::CFG_START_ANGLE:   arc_start = longint'($signed(v[17:0]));
      cap_pkg::CFG_END_ANGLE:     arc_end = longint'($signed(v[17:0]));
      cap_pkg::CFG_POINT_COUNT:   arc_cnt = longint'(v[10:0]);
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_arc(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                             logic [31:0] r, logic [31:0] h, logic [31:0] s,
                             logic [31:0] e, logic [31:0] n);
    write_reg(cap_pkg::CFG_CENTER_X, cx);
    write_reg(cap_pkg::CFG_CENTER_Y, cy);
    write_reg(cap_pkg::CFG_CENTER_Z, cz);
    write_reg(cap_pkg::CFG_ARC_RADIUS, r);
    write_reg(cap_pkg::CFG_HEIGHT_OFFSET, h);
    write_reg(cap_pkg::CFG_START_ANGLE, s);
    write_reg(cap_pkg::CFG_END_ANGLE, e);
    write_reg(cap_pkg::CFG_POINT_COUNT, n);
  endtask

  task automatic test_reset_state();
    send_point(10'd0);
    send_point(10'd1023);
    wait_drained();
  endtask

  task automatic test_extremes();
    program_arc(32'd0, 32'd0, 32'd0, 32'hFF_FFFF, 32'd0, 32'h2_0000, 32'h1_FFFF, 32'd1024);
    send_point(10'd0);
    send_point(10'd1);
    send_point(10'd512);
    send_point(10'd1023);
    wait_drained();
    program_arc(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFF_FFFF, 32'h7FFF_FFFF,
                32'd16384, 32'd16384, 32'd2047);
    send_point(10'd0);
    send_point(10'd1023);
    wait_drained();
    program_arc(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'hFF_FFFF, 32'h8000_0000,
                32'd0, 32'd65536, 32'd8);
    for (int i = 0; i < 10; i++) send_point(10'(i));
    wait_drained();
    program_arc(32'd1000, -32'sd1000, 32'd5, 32'd0, -32'sd5, 32'd49152, -32'sd16384, 32'd0);
    send_point(10'd0);
    send_point(10'd5);
    wait_drained();
  endtask

  task automatic random_arc();
    int pick;
    pick = $urandom_range(0, 9);
    program_arc($urandom, $urandom, $urandom,
                (pick < 2) ? 32'hFF_FFFF : $urandom_range(0, 24'hFF_FFFF),
                $urandom, $urandom, $urandom,
                (pick == 3) ? 32'd2047 : (pick == 4) ? 32'd1 : $urandom_range(1, 1100));
    if (pick >= 5) begin
      write_reg(cap_pkg::CFG_CENTER_X, $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000);
      write_reg(cap_pkg::CFG_CENTER_Y, $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000);
    end
  endtask

  task automatic test_random_arcs(int phases, int per_phase);
    longint lim;
    for (int ph = 0; ph < phases; ph++) begin
      random_arc();
      steady_rx = (ph % 4 == 3);
      lim = (arc_cnt > 1024) ? 1024 : arc_cnt;
      for (int k = 0; k < per_phase; k++) begin
        if ($urandom_range(0, 9) != 0 && lim > 0) paced_point(10'($urandom_range(0, lim - 1)));
        else paced_point(10'($urandom));
      end
      wait_drained();
    end
    steady_rx = 0;
  endtask

  task automatic test_backpressure();
    random_arc();
    hold_req = 1;
    for (int k = 0; k < 80; k++) send_point(10'($urandom));
    wait_drained();
    for (int k = 0; k < 30; k++) paced_point(10'($urandom));
    wait_drained();
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_point_index <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= cap_pkg::CFG_CENTER_X;
    cfg_data <= '0;
    out_ready <= 1'b0;
    {arc_cx, arc_cy, arc_cz, arc_rad, arc_hgt, arc_start, arc_end, arc_cnt} = '0;
    errors = 0;
    points_checked = 0;
    oor_seen = 0;
    sat_seen = 0;
    burst_left = 0;
    hold_req = 0;
    hold_left = 0;
    steady_rx = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_extremes();
    test_random_arcs(8, 30);
    test_backpressure();
    test_random_arcs(2, 15);
    wait_drained();
    $display("Checked %0d points over many arc settings, %0d out of range, %0d saturated.",
             points_checked, oor_seen, sat_seen);
    $display("Covered register extremes, long output stalls and input pauses.");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
